FILE: src/hbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package hbc_pkg;

  localparam int MAX_BINS   = 64;
  localparam int VALUE_BITS = 32;
  localparam int WIDTH_BITS = 31;
  localparam int CNT_BITS   = 7;
  localparam int IDX_W      = $clog2(MAX_BINS + 1);
  localparam int DEPTH      = MAX_BINS + 1;
  localparam int D_W        = VALUE_BITS + 1;
  localparam int KW         = (IDX_W > 1) ? $clog2(IDX_W) : 1;
  localparam int ALU_W      = ((D_W > WIDTH_BITS + IDX_W) ? D_W : WIDTH_BITS + IDX_W) + 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT = 2'd3;

  localparam logic ACT_CLASSIFY = 1'b0;
  localparam logic ACT_WRITE    = 1'b1;

  localparam logic MODE_UNIFORM = 1'b0;
  localparam logic MODE_EDGES   = 1'b1;

  typedef struct packed {
    logic                         action;
    logic signed [VALUE_BITS-1:0] value;
    logic [IDX_W-1:0]             entry_index;
  } hbc_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] bin_index;
    logic             outside;
  } hbc_out_t;

  typedef struct packed {
    logic [ALU_W-1:0] diff;
    logic             ge;
    logic             eq;
  } hbc_cmp_t;

endpackage
`default_nettype wire

FILE: src/hbc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module hbc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

FILE: src/hbc_alu.sv
`timescale 1ns / 1ps
`default_nettype none
module hbc_alu (
  input  logic [hbc_pkg::ALU_W-1:0] a_i,
  input  logic [hbc_pkg::ALU_W-1:0] b_i,
  output hbc_pkg::hbc_cmp_t         cmp_o
);
  import hbc_pkg::*;

  // operands fit in one bit less than ALU_W, so the difference never overflows
  logic [ALU_W-1:0] diff;

  assign diff       = a_i - b_i;
  assign cmp_o.diff = diff;
  assign cmp_o.ge   = ~diff[ALU_W-1];
  assign cmp_o.eq   = (a_i == b_i);

endmodule
`default_nettype wire

FILE: src/histogram_bin_classifier_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Histogram bin classifier.
// Input channel (in_valid_i / in_stall_o / in_data_i): one beat is either a
// classify request or an edge table write. A write updates the table in the
// accept cycle and yields no output beat. A classify yields one output beat
// (out_valid_o / out_stall_i / out_data_o) with the bin and an outside flag.
// Uniform mode: subtract, one range check, then one restoring divide step per
// cycle through the shared subtract/compare unit; a sample below range_min
// ends after the subtract, one whose quotient passes the index range after
// the range check. Edge mode: two table reads for the range test, then one
// table entry per cycle through the same unit (count clamped to 1..64); a
// sample that misses the range ends after the range test. The table RAM has
// one registered read port, which sets the scan rate. in_stall_o is high
// while a classify is in progress, so the next beat is taken the cycle after
// the result issues; writes go back to back. One finished result is held in
// the output register, so a new beat is taken while the previous result
// waits under out_stall_i; a second result waits in the core.
// Configuration (cfg_valid_i / cfg_ready_o) is always ready and is to be
// written only while idle; the core does not enforce this. Reset sets mode 0,
// range_min 0, bin_width 1, bin_count 1.
module histogram_bin_classifier_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  hbc_pkg::hbc_in_t                 in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output hbc_pkg::hbc_out_t                out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [hbc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [hbc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import hbc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUB,
    ST_OVF,
    ST_DIV,
    ST_FIN,
    ST_RD_LO,
    ST_CHK_LO,
    ST_CHK_HI,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e                       state_q;
  logic                         mode_q;
  logic signed [VALUE_BITS-1:0] range_min_q;
  logic [WIDTH_BITS-1:0]        bin_width_q;
  logic [CNT_BITS-1:0]          bin_count_q;

  logic signed [VALUE_BITS-1:0] val_q;
  logic [D_W-1:0]               rem_q;
  logic [IDX_W-1:0]             quot_q;
  logic [KW-1:0]                k_q;
  logic [IDX_W-1:0]             scan_q;
  logic                         ge_lo_q;
  hbc_out_t                     res_q;
  hbc_out_t                     out_q;
  logic                         out_valid_q;

  logic [IDX_W-1:0]             n_eff;
  logic [WIDTH_BITS-1:0]        w_eff;
  logic [ALU_W-1:0]             alu_a;
  logic [ALU_W-1:0]             alu_b;
  hbc_cmp_t                     cmp;
  logic                         in_accept;
  logic                         ram_we;
  logic [IDX_W-1:0]             raddr;
  logic [VALUE_BITS-1:0]        rdata;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    if (bin_count_q == '0) begin
      n_eff = IDX_W'(1);
    end else if (32'(bin_count_q) > 32'(MAX_BINS)) begin
      n_eff = IDX_W'(MAX_BINS);
    end else begin
      n_eff = IDX_W'(bin_count_q);
    end
  end

  assign w_eff = (bin_width_q == '0) ? WIDTH_BITS'(1) : bin_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_UNIFORM;
      range_min_q <= '0;
      bin_width_q <= WIDTH_BITS'(1);
      bin_count_q <= CNT_BITS'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_MODE:      mode_q      <= cfg_data_i[0];
        REG_RANGE_MIN: range_min_q <= VALUE_BITS'(cfg_data_i);
        REG_BIN_WIDTH: bin_width_q <= cfg_data_i[WIDTH_BITS-1:0];
        REG_BIN_COUNT: bin_count_q <= cfg_data_i[CNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign ram_we = in_accept && (in_data_i.action == ACT_WRITE) &&
                  (32'(in_data_i.entry_index) <= 32'(MAX_BINS));

  always_comb begin
    case (state_q)
      ST_CHK_LO: raddr = n_eff;
      ST_CHK_HI: raddr = IDX_W'(1);
      ST_SCAN:   raddr = (scan_q < n_eff) ? scan_q + IDX_W'(1) : '0;
      default:   raddr = '0;
    endcase
  end

  hbc_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_edges (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_data_i.entry_index),
    .wdata_i (in_data_i.value),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    case (state_q)
      ST_SUB: begin
        alu_a = {{(ALU_W-VALUE_BITS){val_q[VALUE_BITS-1]}}, val_q};
        alu_b = {{(ALU_W-VALUE_BITS){range_min_q[VALUE_BITS-1]}}, range_min_q};
      end
      ST_OVF: begin
        alu_a = ALU_W'(rem_q);
        alu_b = ALU_W'(w_eff) << IDX_W;
      end
      ST_DIV: begin
        alu_a = ALU_W'(rem_q);
        alu_b = ALU_W'(w_eff) << k_q;
      end
      ST_CHK_LO, ST_CHK_HI, ST_SCAN: begin
        alu_a = {{(ALU_W-VALUE_BITS){val_q[VALUE_BITS-1]}}, val_q};
        alu_b = {{(ALU_W-VALUE_BITS){rdata[VALUE_BITS-1]}}, rdata};
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  hbc_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .cmp_o (cmp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      val_q       <= '0;
      rem_q       <= '0;
      quot_q      <= '0;
      k_q         <= '0;
      scan_q      <= '0;
      ge_lo_q     <= 1'b0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_accept && (in_data_i.action == ACT_CLASSIFY)) begin
            val_q   <= in_data_i.value;
            quot_q  <= '0;
            state_q <= (mode_q == MODE_EDGES) ? ST_RD_LO : ST_SUB;
          end
        end
        ST_SUB: begin
          rem_q <= cmp.diff[D_W-1:0];
          if (cmp.ge) begin
            state_q <= ST_OVF;
          end else begin
            res_q   <= '{bin_index: n_eff, outside: 1'b1};
            state_q <= ST_DONE;
          end
        end
        ST_OVF: begin
          // quotient beyond the index range can never be a bin or the top edge
          if (cmp.ge) begin
            res_q   <= '{bin_index: n_eff, outside: 1'b1};
            state_q <= ST_DONE;
          end else begin
            k_q     <= KW'(IDX_W - 1);
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (cmp.ge) begin
            rem_q       <= cmp.diff[D_W-1:0];
            quot_q[k_q] <= 1'b1;
          end
          if (k_q == '0) begin
            state_q <= ST_FIN;
          end else begin
            k_q <= k_q - KW'(1);
          end
        end
        ST_FIN: begin
          if (quot_q < n_eff) begin
            res_q <= '{bin_index: quot_q, outside: 1'b0};
          end else if (quot_q == n_eff && rem_q == '0) begin
            res_q <= '{bin_index: n_eff - IDX_W'(1), outside: 1'b0};
          end else begin
            res_q <= '{bin_index: n_eff, outside: 1'b1};
          end
          state_q <= ST_DONE;
        end
        ST_RD_LO: begin
          state_q <= ST_CHK_LO;
        end
        ST_CHK_LO: begin
          ge_lo_q <= cmp.ge;
          state_q <= ST_CHK_HI;
        end
        ST_CHK_HI: begin
          if (ge_lo_q && !cmp.ge) begin
            scan_q  <= IDX_W'(1);
            state_q <= ST_SCAN;
          end else if (cmp.eq) begin
            res_q   <= '{bin_index: n_eff - IDX_W'(1), outside: 1'b0};
            state_q <= ST_DONE;
          end else begin
            res_q   <= '{bin_index: n_eff, outside: 1'b1};
            state_q <= ST_DONE;
          end
        end
        ST_SCAN: begin
          if (!cmp.ge) begin
            res_q   <= '{bin_index: scan_q - IDX_W'(1), outside: 1'b0};
            state_q <= ST_DONE;
          end else if (scan_q >= n_eff) begin
            res_q   <= '{bin_index: n_eff, outside: 1'b1};
            state_q <= ST_DONE;
          end else begin
            scan_q <= scan_q + IDX_W'(1);
          end
        end
        ST_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_write_no_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (in_data_i.action == ACT_WRITE) |=> state_q == ST_IDLE)
    else $error("edge write started a classification");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> (scan_q >= IDX_W'(1)) && (scan_q <= n_eff))
    else $error("edge scan index out of range");

  a_result_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE |->
      (res_q.outside && res_q.bin_index == n_eff) ||
      (!res_q.outside && res_q.bin_index < n_eff))
    else $error("result bin inconsistent with outside flag");

  a_div_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIN |-> $past(state_q) == ST_DIV && $past(k_q) == '0)
    else $error("divide finished early");

endmodule
`default_nettype wire
